// ===== rtl/hfd_pkg.sv =====
`timescale 1ns / 1ps

package hfd_pkg;

  localparam int NODE_SLOTS_DEF  = 512;
  localparam int STACK_SLOTS_DEF = 256;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam logic [1:0] STAT_SYM  = 2'd0;
  localparam logic [1:0] STAT_DONE = 2'd1;
  localparam logic [1:0] STAT_BAD  = 2'd2;

  // One input beat after classification.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_star;
    logic       is_bslash;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] symbol;
    logic [1:0] status;
    logic       run_end;
  } out_item_t;

endpackage

// ===== rtl/hfd_ram.sv =====
`timescale 1ns / 1ps

module hfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ===== rtl/hfd_fifo.sv =====
`timescale 1ns / 1ps

module hfd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

// ===== rtl/hfd_core.sv =====
`timescale 1ns / 1ps

module hfd_core import hfd_pkg::*; #(
  parameter int NODE_SLOTS  = NODE_SLOTS_DEF,
  parameter int STACK_SLOTS = STACK_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      f_empty,
  input  in_item_t  f_item,
  output logic      f_pop,
  input  logic      o_full,
  output logic      o_push,
  output out_item_t o_item
);

  localparam int NIW = $clog2(NODE_SLOTS);
  localparam int NFW = $clog2(NODE_SLOTS + 1);
  localparam int STW = $clog2(STACK_SLOTS + 1);
  localparam int SAW = (STACK_SLOTS > 1) ? $clog2(STACK_SLOTS) : 1;
  localparam int NW  = NIW + 9;

  typedef enum logic [2:0] {
    PH_HDR1, PH_HDR2, PH_TREE, PH_SKIP, PH_DATA, PH_HALT
  } phase_t;

  typedef enum logic [2:0] {
    ST_GET, ST_PATCH, ST_ADD, ST_WALK, ST_FLUSH, ST_FIN, ST_ERR
  } st_t;

  phase_t         phase_r, phase_nxt, fin_ph, add_ph;
  st_t            st_r, st_nxt;
  logic [2:0]     pad_r, pad_nxt;
  logic [4:0]     hi_r, hi_nxt;
  logic [12:0]    left_r, left_nxt, left_dec, tsize;
  logic           esc_r, esc_nxt;
  logic [STW-1:0] top_r, top_nxt;
  logic [NFW-1:0] nfree_r, nfree_nxt;
  logic           prev_leaf_r, prev_leaf_nxt;
  logic [NW-1:0]  root_e_r, root_e_nxt;
  logic           cur_root_r, cur_root_nxt;
  logic [NIW-1:0] cur_idx_r, cur_idx_nxt;
  logic [NW-1:0]  cur_e_r, cur_e_nxt;
  logic           pend_r, pend_nxt;
  logic [NIW-1:0] pend_idx_r, pend_idx_nxt;
  logic [7:0]     sh_r, sh_nxt;
  logic           last_r, last_nxt;
  logic           kind_leaf_r, kind_leaf_nxt;
  logic [3:0]     bi_r, bi_nxt, nbits_r, nbits_nxt;
  logic           hold_v_r, hold_v_nxt;
  logic [7:0]     hold_sym_r, hold_sym_nxt;

  logic           fin_last, fin_err, node_kind, node_leaf;
  logic           emit;
  logic [7:0]     emit_sym;
  logic           b_root;
  logic [NIW-1:0] b_idx, child;
  logic [NW-1:0]  b_e;
  logic [NIW:0]   idx_inc;

  logic           node_we, node_re;
  logic [NIW-1:0] node_waddr, node_raddr;
  logic [NW-1:0]  node_wdata, node_rdata;
  logic           stk_we, stk_re;
  logic [SAW-1:0] stk_waddr, stk_raddr;
  logic [NIW-1:0] stk_wdata, stk_rdata;

  hfd_ram #(.WIDTH(NW), .DEPTH(NODE_SLOTS)) u_nodes (
    .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .re(node_re), .raddr(node_raddr), .rdata(node_rdata)
  );

  hfd_ram #(.WIDTH(NIW), .DEPTH(STACK_SLOTS)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .re(stk_re), .raddr(stk_raddr), .rdata(stk_rdata)
  );

  // Phase that the tree byte leaves behind, used by the end-of-tree check.
  assign add_ph   = (kind_leaf_r && top_r == '0) ? PH_SKIP : PH_TREE;
  assign fin_ph   = (st_r == ST_ADD) ? add_ph : phase_r;
  assign fin_last = (st_r == ST_ADD) ? last_r : f_item.last;
  assign left_dec = left_r - 13'd1;
  assign fin_err  = ((left_dec == '0) && (fin_ph != PH_SKIP)) || fin_last;
  assign tsize    = {hi_r, f_item.data};

  always_comb begin
    phase_nxt     = phase_r;
    st_nxt        = st_r;
    pad_nxt       = pad_r;
    hi_nxt        = hi_r;
    left_nxt      = left_r;
    esc_nxt       = esc_r;
    top_nxt       = top_r;
    nfree_nxt     = nfree_r;
    prev_leaf_nxt = prev_leaf_r;
    root_e_nxt    = root_e_r;
    cur_root_nxt  = cur_root_r;
    cur_idx_nxt   = cur_idx_r;
    cur_e_nxt     = cur_e_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    sh_nxt        = sh_r;
    last_nxt      = last_r;
    kind_leaf_nxt = kind_leaf_r;
    bi_nxt        = bi_r;
    nbits_nxt     = nbits_r;
    hold_v_nxt    = hold_v_r;
    hold_sym_nxt  = hold_sym_r;
    f_pop         = 1'b0;
    o_push        = 1'b0;
    o_item        = '{symbol: hold_sym_r, status: STAT_SYM, run_end: 1'b0};
    node_we       = 1'b0;
    node_waddr    = nfree_r[NIW-1:0];
    node_wdata    = '0;
    node_re       = 1'b0;
    node_raddr    = '0;
    stk_we        = 1'b0;
    stk_waddr     = top_r[SAW-1:0];
    stk_wdata     = nfree_r[NIW-1:0];
    stk_re        = 1'b0;
    stk_raddr     = SAW'(top_r - 1'b1);
    node_kind     = 1'b0;
    node_leaf     = 1'b0;
    emit          = 1'b0;
    emit_sym      = '0;
    b_root        = cur_root_r;
    b_idx         = cur_root_r ? '0 : cur_idx_r;
    b_e           = cur_root_r ? root_e_r : cur_e_r;
    idx_inc       = '0;
    child         = '0;

    case (st_r)
      ST_GET: begin
        if (!f_empty) begin
          f_pop    = 1'b1;
          sh_nxt   = f_item.data;
          last_nxt = f_item.last;
          case (phase_r)
            PH_HDR1: begin
              pad_nxt = f_item.data[7:5];
              hi_nxt  = f_item.data[4:0];
              if (f_item.last) st_nxt = ST_ERR;
              else phase_nxt = PH_HDR2;
            end
            PH_HDR2: begin
              left_nxt = tsize;
              if (f_item.last || tsize == '0) st_nxt = ST_ERR;
              else phase_nxt = PH_TREE;
            end
            PH_SKIP: begin
              left_nxt  = left_dec;
              phase_nxt = (left_dec == '0) ? PH_DATA : PH_SKIP;
              if (fin_err) st_nxt = ST_ERR;
            end
            PH_TREE: begin
              if (esc_r) begin
                esc_nxt   = 1'b0;
                node_kind = 1'b1;
                node_leaf = 1'b1;
              end else if (f_item.is_bslash) begin
                esc_nxt = 1'b1;
              end else begin
                node_kind = 1'b1;
                node_leaf = !f_item.is_star;
              end
              kind_leaf_nxt = node_leaf;
              if (!node_kind) begin
                left_nxt = left_dec;
                if (fin_err) st_nxt = ST_ERR;
              end else if (nfree_r == NFW'(NODE_SLOTS)) begin
                st_nxt = ST_ERR;
              end else if (nfree_r != '0 && prev_leaf_r) begin
                // The previous node closed a left subtree: pop its parent.
                if (top_r == '0) begin
                  st_nxt = ST_ERR;
                end else begin
                  stk_re  = 1'b1;
                  top_nxt = top_r - 1'b1;
                  st_nxt  = ST_PATCH;
                end
              end else begin
                st_nxt = ST_ADD;
              end
            end
            PH_DATA: begin
              nbits_nxt = f_item.last ? (4'd8 - {1'b0, pad_r}) : 4'd8;
              bi_nxt    = '0;
              st_nxt    = ST_WALK;
            end
            default: ;
          endcase
        end
      end

      ST_PATCH: begin
        node_we    = 1'b1;
        node_waddr = stk_rdata;
        node_wdata = {1'b0, nfree_r[NIW-1:0], 8'h00};
        if (stk_rdata == '0) root_e_nxt = node_wdata;
        st_nxt = ST_ADD;
      end

      ST_ADD: begin
        if (!kind_leaf_r && top_r >= STW'(STACK_SLOTS)) begin
          st_nxt = ST_ERR;
        end else begin
          node_we    = 1'b1;
          node_wdata = kind_leaf_r ? {1'b1, {NIW{1'b0}}, sh_r} : '0;
          if (nfree_r == '0) root_e_nxt = node_wdata;
          if (!kind_leaf_r) begin
            stk_we  = 1'b1;
            top_nxt = top_r + 1'b1;
          end
          nfree_nxt     = nfree_r + 1'b1;
          prev_leaf_nxt = kind_leaf_r;
          left_nxt      = left_dec;
          phase_nxt     = (left_dec == '0) ? PH_DATA : fin_ph;
          st_nxt        = fin_err ? ST_ERR : ST_GET;
        end
      end

      ST_WALK: begin
        if (!o_full) begin
          // Resolve the child fetched for the previous bit.
          if (pend_r) begin
            if (node_rdata[NW-1]) begin
              emit     = 1'b1;
              emit_sym = node_rdata[7:0];
              b_root   = 1'b1;
              b_idx    = '0;
              b_e      = root_e_r;
            end else begin
              b_root = 1'b0;
              b_idx  = pend_idx_r;
              b_e    = node_rdata;
            end
          end
          if (bi_r < nbits_r) begin
            bi_nxt = bi_r + 1'b1;
            sh_nxt = {sh_r[6:0], 1'b0};
            if (b_e[NW-1]) begin
              // Single-leaf tree: every bit gives the root symbol.
              emit         = 1'b1;
              emit_sym     = b_e[7:0];
              pend_nxt     = 1'b0;
              cur_root_nxt = 1'b1;
            end else begin
              idx_inc    = {1'b0, b_idx} + 1'b1;
              child      = sh_r[7] ? b_e[NIW+7:8] :
                           ((idx_inc == (NIW+1)'(NODE_SLOTS)) ? '0 : idx_inc[NIW-1:0]);
              node_re      = 1'b1;
              node_raddr   = child;
              pend_nxt     = 1'b1;
              pend_idx_nxt = child;
            end
          end else begin
            pend_nxt     = 1'b0;
            cur_root_nxt = b_root;
            cur_idx_nxt  = b_idx;
            cur_e_nxt    = b_e;
            st_nxt       = ST_FLUSH;
          end
        end
      end

      ST_FLUSH: begin
        if (!hold_v_r || !o_full) begin
          if (hold_v_r) begin
            o_push         = 1'b1;
            o_item.run_end = !last_r;
          end
          hold_v_nxt = 1'b0;
          st_nxt     = last_r ? ST_FIN : ST_GET;
        end
      end

      ST_FIN, ST_ERR: begin
        if (!o_full) begin
          o_push    = 1'b1;
          o_item    = '{symbol: 8'h00,
                        status: (st_r == ST_FIN) ? STAT_DONE : STAT_BAD,
                        run_end: 1'b1};
          phase_nxt = PH_HALT;
          st_nxt    = ST_GET;
        end
      end

      default: st_nxt = ST_GET;
    endcase

    // Symbols pass through a one-beat hold so that run_end can be set on
    // the last one of a byte.
    if (emit) begin
      if (hold_v_r) o_push = 1'b1;
      hold_v_nxt   = 1'b1;
      hold_sym_nxt = emit_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR1;
      st_r        <= ST_GET;
      pad_r       <= '0;
      hi_r        <= '0;
      left_r      <= '0;
      esc_r       <= 1'b0;
      top_r       <= '0;
      nfree_r     <= '0;
      prev_leaf_r <= 1'b0;
      cur_root_r  <= 1'b1;
      pend_r      <= 1'b0;
      hold_v_r    <= 1'b0;
      bi_r        <= '0;
      nbits_r     <= '0;
    end else begin
      phase_r     <= phase_nxt;
      st_r        <= st_nxt;
      pad_r       <= pad_nxt;
      hi_r        <= hi_nxt;
      left_r      <= left_nxt;
      esc_r       <= esc_nxt;
      top_r       <= top_nxt;
      nfree_r     <= nfree_nxt;
      prev_leaf_r <= prev_leaf_nxt;
      cur_root_r  <= cur_root_nxt;
      pend_r      <= pend_nxt;
      hold_v_r    <= hold_v_nxt;
      bi_r        <= bi_nxt;
      nbits_r     <= nbits_nxt;
    end
    root_e_r    <= root_e_nxt;
    cur_idx_r   <= cur_idx_nxt;
    cur_e_r     <= cur_e_nxt;
    pend_idx_r  <= pend_idx_nxt;
    sh_r        <= sh_nxt;
    last_r      <= last_nxt;
    kind_leaf_r <= kind_leaf_nxt;
    hold_sym_r  <= hold_sym_nxt;
  end

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    o_push |-> !o_full) else $error("result pushed into a full queue");

  a_pend_walk: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> st_r == ST_WALK) else $error("node fetch pending outside walk");

  a_bit_count: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_WALK |-> bi_r <= nbits_r) else $error("bit count overran");

  a_halt_clean: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HALT |-> !hold_v_r) else $error("symbol left held after halt");

  a_pop_tree: assert property (@(posedge clk) disable iff (!rst_n)
    stk_re |=> st_r == ST_PATCH) else $error("stack read not followed by patch");

endmodule

// ===== rtl/huffman_file_decoder.sv =====
`timescale 1ns / 1ps

// Streaming Huffman file decoder.
// Input queue: drive in_byte / in_last_byte with in_push; a beat is taken at
// a clock edge with in_push high and in_full low. The first two bytes are the
// header, the next bytes the preorder tree, the rest data; mark the final byte
// with in_last_byte.
// Result queue: while out_empty is low the oldest result sits on out_symbol,
// out_status (0 symbol, 1 finished, 2 malformed) and out_run_end; out_pop
// takes it. out_run_end marks the last result caused by one input byte.
// Steps: header bytes and escape prefixes are a single fetch step each; other tree
// bytes take classify and node write, or stack read, parent patch and node write
// when they close a left subtree. A data byte takes a fetch, one node-table read
// per bit plus one more to resolve the last read, and a flush; a status beat
// adds one more step.
// Two-deep queues on both sides let input and output stall independently;
// when the result queue is full the decoder simply waits.
// Reset (rst_n low, synchronous) returns to the first header byte; after a
// finish or error status all further bytes are taken and dropped until reset.
module huffman_file_decoder import hfd_pkg::*; #(
  parameter int NODE_SLOTS  = NODE_SLOTS_DEF,
  parameter int STACK_SLOTS = STACK_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_byte,
  input  logic       in_last_byte,
  input  logic       in_push,
  output logic       in_full,
  output logic [7:0] out_symbol,
  output logic [1:0] out_status,
  output logic       out_run_end,
  output logic       out_empty,
  input  logic       out_pop
);

  in_item_t  in_item, f_item;
  out_item_t o_item, q_item;
  logic      f_empty, f_pop, o_full, o_push;

  assign in_item = '{data: in_byte, last: in_last_byte,
                     is_star: (in_byte == CH_STAR),
                     is_bslash: (in_byte == CH_BSLASH)};

  hfd_fifo #(.WIDTH($bits(in_item_t)), .DEPTH(QUEUE_DEPTH)) u_inq (
    .clk(clk), .rst_n(rst_n), .push(in_push), .din(in_item), .full(in_full),
    .pop(f_pop), .dout(f_item), .empty(f_empty)
  );

  hfd_core #(.NODE_SLOTS(NODE_SLOTS), .STACK_SLOTS(STACK_SLOTS)) u_core (
    .clk(clk), .rst_n(rst_n), .f_empty(f_empty), .f_item(f_item), .f_pop(f_pop),
    .o_full(o_full), .o_push(o_push), .o_item(o_item)
  );

  hfd_fifo #(.WIDTH($bits(out_item_t)), .DEPTH(QUEUE_DEPTH)) u_outq (
    .clk(clk), .rst_n(rst_n), .push(o_push), .din(o_item), .full(o_full),
    .pop(out_pop), .dout(q_item), .empty(out_empty)
  );

  assign out_symbol  = q_item.symbol;
  assign out_status  = q_item.status;
  assign out_run_end = q_item.run_end;

endmodule
